/* src/floyd_steinberg_dither_macros.svh */
// Assertion wrappers shared by the dither RTL.
`ifndef FLOYD_STEINBERG_DITHER_MACROS_SVH
`define FLOYD_STEINBERG_DITHER_MACROS_SVH

`ifndef SYNTH
// Clocked check, masked while reset is asserted.
`define FSD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Clocked check that also holds across reset.
`define FSD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FSD_ASSERT(lbl, clk, rstn, prop, msg)
`define FSD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* src/fsd_pkg.sv */
package fsd_pkg;

    localparam int MAX_WIDTH_DEF = 256;
    localparam int CFG_W         = 9;
    localparam int PIX_W         = 8;

    localparam logic [CFG_W-1:0] WIDTH_RESET = 9'd200;

    // Diffusion weights in sixteenths
    localparam logic [2:0] W_UP_LEFT  = 3'd1;
    localparam logic [2:0] W_UP       = 3'd5;
    localparam logic [2:0] W_UP_RIGHT = 3'd3;
    localparam logic [2:0] W_LEFT     = 3'd7;

    // v + trunc(e * wt / 16), clamped to 0..255; e is a signed 8-bit error
    function automatic logic [PIX_W-1:0] sat_add(input logic [PIX_W-1:0] v,
                                                 input logic [PIX_W-1:0] e,
                                                 input logic [2:0]       wt);
        logic signed [10:0] prod;
        logic signed [10:0] quot;
        logic signed [10:0] sum;
        prod = 11'($signed(e)) * 11'($signed({1'b0, wt}));
        quot = (prod + (prod[10] ? 11'sd15 : 11'sd0)) >>> 4;
        sum  = quot + 11'($signed({1'b0, v}));
        if (sum > 11'sd255) begin
            return 8'd255;
        end else if (sum[10]) begin
            return 8'd0;
        end else begin
            return sum[PIX_W-1:0];
        end
    endfunction

endpackage

/* src/fsd_pix_if.sv */
interface fsd_pix_if;
    logic                    valid;
    logic                    ready;
    logic [fsd_pkg::PIX_W-1:0] gray_in;
    logic                    frame_start;

    modport source (output valid, output gray_in, output frame_start, input ready);
    modport sink   (input valid, input gray_in, input frame_start, output ready);
endinterface

/* src/fsd_res_if.sv */
interface fsd_res_if;
    logic valid;
    logic ready;
    logic pixel_white;
    logic row_end;

    modport source (output valid, output pixel_white, output row_end, input ready);
    modport sink   (input valid, input pixel_white, input row_end, output ready);
endinterface

/* src/fsd_cfg_if.sv */
interface fsd_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [fsd_pkg::CFG_W-1:0] image_width;

    modport source (output valid, output image_width, input ready);
    modport sink   (input valid, input image_width, output ready);
endinterface

/* src/floyd_steinberg_dither.sv */
// Floyd-Steinberg error-diffusion dither, grey to one bit per pixel.
// i_pix (sink): valid/ready with gray_in (8-bit grey) and frame_start, which
//   marks the first pixel of an image and restarts row and column tracking.
// o_res (source): valid/ready with pixel_white and row_end, one transaction
//   for every pixel taken, in the same order.
// i_cfg (sink): image_width, pixels per row; always ready. Write it only
//   while no pixel is in flight. 0 acts as 1, values above MAX_WIDTH clamp.
// Throughput: one pixel per clock while o_res is ready. The only loop is the left-neighbour
//   error feeding the next pixel, which is held in r_left_err between pixels.
// Pipeline: an accepted pixel waits in the input register, and its result is
//   offered on o_res from the output register.
// The previous row's errors sit in a MAX_WIDTH-entry line buffer with two
//   registered read ports, prefetching columns x and x+1 for the next pixel.
// Reset: control state clears, width returns to 200. The line buffer is not
//   cleared; the first row after frame_start never reads it. No clearing pass.
// Stall: when o_res is held off, the result waits in the output register and
//   one more pixel can be taken into the input register; further pixels see
//   ready low until the receiver drains.
module floyd_steinberg_dither #(
    parameter int MAX_WIDTH = fsd_pkg::MAX_WIDTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    fsd_pix_if.sink      i_pix,
    fsd_res_if.source    o_res,
    fsd_cfg_if.sink      i_cfg
);
    import fsd_pkg::*;

`include "floyd_steinberg_dither_macros.svh"

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int LEN_W = $clog2(MAX_WIDTH + 1);
    localparam int WW    = (CFG_W > LEN_W) ? CFG_W : LEN_W;

    // Input register
    logic             r_s1_valid;
    logic [PIX_W-1:0] r_s1_gray;
    logic             r_s1_fs;

    // Output register
    logic r_out_valid;
    logic r_out_white;
    logic r_out_row_end;

    // Scan state
    logic [COL_W-1:0] r_col;
    logic             r_first_row;
    logic [PIX_W-1:0] r_left_err;
    logic [PIX_W-1:0] r_up_left;
    logic [CFG_W-1:0] r_image_width;

    // Datapath
    logic             adv;
    logic [WW-1:0]    wcfg;
    logic [WW-1:0]    w_eff;
    logic [COL_W-1:0] col_e;
    logic             first_e;
    logic [PIX_W-1:0] left_e;
    logic [PIX_W-1:0] ul_e;
    logic             last;
    logic [PIX_W-1:0] up_cur;
    logic [PIX_W-1:0] up_nxt;
    logic [PIX_W-1:0] v;
    logic             white;
    logic [PIX_W-1:0] err;
    logic [COL_W-1:0] n_col;
    logic [COL_W-1:0] rd_addr_b;

    // Move the held pixel into the output register when that slot frees up
    assign adv         = r_s1_valid && (!r_out_valid || o_res.ready);
    assign i_pix.ready = !r_s1_valid || adv;
    assign i_cfg.ready = 1'b1;

    // Effective row length, clamped to 1..MAX_WIDTH
    always_comb begin
        wcfg = WW'(r_image_width);
        if (wcfg == '0) begin
            w_eff = WW'(1);
        end else if (wcfg > WW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = wcfg;
        end
    end

    // Frame start restarts the scan before this pixel is processed
    always_comb begin
        col_e   = r_s1_fs ? '0 : r_col;
        first_e = r_s1_fs | r_first_row;
        left_e  = r_s1_fs ? '0 : r_left_err;
        ul_e    = r_s1_fs ? '0 : r_up_left;
        last    = (WW'(col_e) + WW'(1)) >= w_eff;
    end

    // Clamped add chain: upper-left, above, upper-right, then left
    always_comb begin
        v = r_s1_gray;
        if (!first_e) begin
            if (col_e != '0) begin
                v = sat_add(v, ul_e, W_UP_LEFT);
            end
            v = sat_add(v, up_cur, W_UP);
            if (!last) begin
                v = sat_add(v, up_nxt, W_UP_RIGHT);
            end
        end
        if (col_e != '0) begin
            v = sat_add(v, left_e, W_LEFT);
        end
        white = v[PIX_W-1];
        // v - 255 wraps to v + 1 in eight bits
        err   = white ? (v + PIX_W'(1)) : v;
    end

    // Prefetch the line entries that the next pixel will need
    always_comb begin
        if (adv) begin
            n_col = last ? '0 : (col_e + COL_W'(1));
        end else begin
            n_col = r_col;
        end
        if (n_col == COL_W'(MAX_WIDTH - 1)) begin
            rd_addr_b = '0;
        end else begin
            rd_addr_b = n_col + COL_W'(1);
        end
    end

    fsd_line_buf #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (PIX_W)
    ) u_line_buf (
        .i_clk       (i_clk),
        .i_wr_en     (adv),
        .i_wr_addr   (col_e),
        .i_wr_data   (err),
        .i_rd_addr_a (n_col),
        .i_rd_addr_b (rd_addr_b),
        .o_rd_data_a (up_cur),
        .o_rd_data_b (up_nxt)
    );

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_col         <= '0;
            r_first_row   <= 1'b1;
            r_left_err    <= '0;
            r_up_left     <= '0;
            r_image_width <= WIDTH_RESET;
        end else begin
            if (i_cfg.valid) begin
                r_image_width <= i_cfg.image_width;
            end
            if (i_pix.valid && i_pix.ready) begin
                r_s1_valid <= 1'b1;
            end else if (adv) begin
                r_s1_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (adv) begin
                // Wrap to the next row on the last pixel, else step right
                r_col       <= n_col;
                r_first_row <= last ? 1'b0 : first_e;
                r_left_err  <= last ? '0 : err;
                r_up_left   <= last ? '0 : up_cur;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_pix.valid && i_pix.ready) begin
            r_s1_gray <= i_pix.gray_in;
            r_s1_fs   <= i_pix.frame_start;
        end
        if (adv) begin
            r_out_white   <= white;
            r_out_row_end <= last;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.pixel_white = r_out_white;
    assign o_res.row_end     = r_out_row_end;

    `FSD_ASSERT(a_row_wrap, i_clk, i_rst_n,
        (adv && last) |=> (r_col == '0 && !r_first_row), "row end did not restart the column")
    `FSD_ASSERT(a_left_clear, i_clk, i_rst_n,
        (adv && last) |=> (r_left_err == '0 && r_up_left == '0), "error carried across a row end")
    `FSD_ASSERT(a_hold_input, i_clk, i_rst_n,
        (r_s1_valid && r_out_valid && !o_res.ready) |-> !i_pix.ready, "input taken while full")
    `FSD_ASSERT(a_out_fill, i_clk, i_rst_n,
        adv |=> r_out_valid, "advanced pixel missing from the output register")
    `FSD_ASSERT_ALWAYS(a_reset_empty, i_clk,
        !i_rst_n |=> (!r_s1_valid && !r_out_valid), "pipeline not empty after reset")

endmodule

/* src/fsd_line_buf.sv */
module fsd_line_buf #(
    parameter int DEPTH  = 256,
    parameter int DATA_W = 8
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [DATA_W-1:0]        i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_b,
    output logic [DATA_W-1:0]        o_rd_data_a,
    output logic [DATA_W-1:0]        o_rd_data_b
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_a;
    logic [DATA_W-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered reads; forward a same-edge write so the data is never stale
    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_wr_addr == i_rd_addr_a)) begin
            r_rd_a <= i_wr_data;
        end else begin
            r_rd_a <= r_mem[i_rd_addr_a];
        end
        if (i_wr_en && (i_wr_addr == i_rd_addr_b)) begin
            r_rd_b <= i_wr_data;
        end else begin
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule
